@@ hw/rtl/vca_pkg.sv @@
package vca_pkg;

  // table geometry
  localparam int CHANNELS = 8;
  localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // fixed field widths
  localparam int ACT_W  = 2;
  localparam int ENT_W  = 16;
  localparam int SUB_W  = 4;
  localparam int NOW_W  = 31;
  localparam int LEN_W  = 24;
  localparam int TIME_W = 32;
  localparam int CIDX_W = 6;

  // action codes
  localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd0;
  localparam logic [ACT_W-1:0] ACT_STOP  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  // sub-channel codes
  localparam logic [SUB_W-1:0] SUB_NONE = 4'h0;
  localparam logic [SUB_W-1:0] SUB_ANY  = 4'hf;

  // starting value of the least-remaining-time search
  localparam logic [TIME_W-1:0] BEST_INIT = 32'h7fff_ffff;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic apply;
  } vca_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_op;
    logic hit;
    logic last;
  } vca_sts_t;

endpackage

@@ hw/rtl/voice_channel_allocator.sv @@
// Voice channel allocator over a table of CHANNELS dynamic sound channels.
// Input channel (in_valid/in_ready) carries one request item: action
// (allocate, stop, clear all), entity, entity_channel, now and sound_length.
// Output channel (out_valid/out_ready) returns one result item per request:
// done_res, channel_index and stole_active.
// Configuration channel (cfg_valid/cfg_ready, cfg_data) writes view_entity;
// it is always ready and should be written only while the block is idle.
// Sequence: allocate and stop walk the table one entry per cycle until an
// exact match or the last entry, then update the table and register the
// result; clear all and the unused code go straight to the update. The
// table read port of the scan sets this pace.
// One item is in flight at a time; a new item is taken while the previous
// result still waits in the output register.
// When the receiver stalls, the finished result stays held and the next item
// waits before its table update until that result is taken.
// Reset (rst, synchronous) empties the table and sets view_entity to 0.
module voice_channel_allocator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [vca_pkg::ACT_W-1:0]        action,
  input  logic [vca_pkg::ENT_W-1:0]        entity,
  input  logic signed [vca_pkg::SUB_W-1:0] entity_channel,
  input  logic [vca_pkg::NOW_W-1:0]        now,
  input  logic [vca_pkg::LEN_W-1:0]        sound_length,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             done_res,
  output logic [vca_pkg::CIDX_W-1:0]       channel_index,
  output logic                             stole_active,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [vca_pkg::ENT_W-1:0]        cfg_data
);
  import vca_pkg::*;

  vca_cmd_t cmd;
  vca_sts_t sts;

  assign cfg_ready = 1'b1;

  // sequencer
  vca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // table and scan datapath
  vca_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .action         (action),
    .entity         (entity),
    .entity_channel (entity_channel),
    .now            (now),
    .sound_length   (sound_length),
    .cfg_wr         (cfg_valid && cfg_ready),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .sts            (sts),
    .done_res       (done_res),
    .channel_index  (channel_index),
    .stole_active   (stole_active)
  );

  // one item at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted while another is in flight");

  // a failed or cleared request reports index zero and no steal
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !done_res) |-> (channel_index == '0) && !stole_active)
    else $error("result without a channel carries a nonzero index or steal");

  // table update only with a free result slot
  a_apply_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.apply |-> (!out_valid || out_ready))
    else $error("result overwritten before it was taken");

  // scan only runs between acceptance and the update
  a_scan_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> !in_ready && !cmd.apply)
    else $error("scan step outside a busy item");

endmodule

@@ hw/rtl/vca_dp.sv @@
module vca_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [vca_pkg::ACT_W-1:0]     action,
  input  logic [vca_pkg::ENT_W-1:0]     entity,
  input  logic signed [vca_pkg::SUB_W-1:0] entity_channel,
  input  logic [vca_pkg::NOW_W-1:0]     now,
  input  logic [vca_pkg::LEN_W-1:0]     sound_length,
  input  logic                          cfg_wr,
  input  logic [vca_pkg::ENT_W-1:0]     cfg_data,
  input  vca_pkg::vca_cmd_t             cmd,
  output vca_pkg::vca_sts_t             sts,
  output logic                          done_res,
  output logic [vca_pkg::CIDX_W-1:0]    channel_index,
  output logic                          stole_active
);
  import vca_pkg::*;

  // channel table
  logic [ENT_W-1:0]  own_ent [CHANNELS];
  logic [SUB_W-1:0]  own_sub [CHANNELS];
  logic [TIME_W-1:0] end_t   [CHANNELS];
  logic [CHANNELS-1:0] playing;

  logic [ENT_W-1:0] view_entity;

  // latched item
  logic [ACT_W-1:0] req_action;
  logic [ENT_W-1:0] req_ent;
  logic [SUB_W-1:0] req_sub;
  logic [NOW_W-1:0] req_now;
  logic [LEN_W-1:0] req_len;

  // scan state
  logic [IDX_W-1:0]  cnt;
  logic [TIME_W-1:0] best;
  logic [IDX_W-1:0]  pick;
  logic              found;
  logic              pick_play;

  logic [ENT_W-1:0]  sel_ent;
  logic [SUB_W-1:0]  sel_sub;
  logic [TIME_W-1:0] sel_end;
  logic              sel_play;
  logic              ent_eq;
  logic              alloc_hit;
  logic              stop_hit;
  logic              hit;
  logic              skip;
  logic [TIME_W-1:0] left;
  logic              better;
  logic [TIME_W-1:0] claim_end;
  logic              is_alloc;

  // entry under the scan pointer
  assign sel_ent  = own_ent[cnt];
  assign sel_sub  = own_sub[cnt];
  assign sel_end  = end_t[cnt];
  assign sel_play = playing[cnt];

  assign is_alloc  = (req_action == ACT_ALLOC);
  assign ent_eq    = (sel_ent == req_ent);
  assign alloc_hit = (req_sub != SUB_NONE) && ent_eq &&
                     ((sel_sub == req_sub) || (req_sub == SUB_ANY));
  assign stop_hit  = ent_eq && (sel_sub == req_sub);
  assign hit       = is_alloc ? alloc_hit : stop_hit;

  // listener's playing sounds are protected from other entities
  assign skip   = (sel_ent == view_entity) && (req_ent != view_entity) && sel_play;
  assign left   = sel_end - {1'b0, req_now};
  assign better = !skip && ($signed(left) < $signed(best));

  assign claim_end = {1'b0, req_now} + {{(TIME_W-LEN_W){1'b0}}, req_len};

  assign sts.scan_op = (action == ACT_ALLOC) || (action == ACT_STOP);
  assign sts.hit     = hit;
  assign sts.last    = (cnt == IDX_W'(CHANNELS - 1));

  // view entity register
  always_ff @(posedge clk) begin
    if (rst) begin
      view_entity <= '0;
    end else if (cfg_wr) begin
      view_entity <= cfg_data;
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_action <= action;
      req_ent    <= entity;
      req_sub    <= entity_channel;
      req_now    <= now;
      req_len    <= sound_length;
    end
  end

  // scan pointer and best candidate
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      found     <= 1'b0;
      best      <= BEST_INIT;
      pick      <= '0;
      pick_play <= 1'b0;
    end else if (cmd.load) begin
      cnt       <= '0;
      found     <= 1'b0;
      best      <= BEST_INIT;
      pick      <= '0;
      pick_play <= 1'b0;
    end else if (cmd.step) begin
      cnt <= cnt + 1'b1;
      if (hit) begin
        found     <= 1'b1;
        pick      <= cnt;
        pick_play <= sel_play;
      end else if (is_alloc && better) begin
        found     <= 1'b1;
        best      <= left;
        pick      <= cnt;
        pick_play <= sel_play;
      end
    end
  end

  // table update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        own_ent[i] <= '0;
        own_sub[i] <= '0;
        end_t[i]   <= '0;
      end
      playing <= '0;
    end else if (cmd.apply) begin
      case (req_action)
        ACT_ALLOC: begin
          if (found) begin
            own_ent[pick] <= req_ent;
            own_sub[pick] <= req_sub;
            end_t[pick]   <= claim_end;
            playing[pick] <= 1'b1;
          end
        end
        ACT_STOP: begin
          if (found) begin
            end_t[pick]   <= '0;
            playing[pick] <= 1'b0;
          end
        end
        ACT_CLEAR: begin
          for (int i = 0; i < CHANNELS; i++) begin
            own_ent[i] <= '0;
            own_sub[i] <= '0;
            end_t[i]   <= '0;
          end
          playing <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      case (req_action)
        ACT_ALLOC, ACT_STOP: begin
          done_res      <= found;
          channel_index <= found ? CIDX_W'(pick) : '0;
          stole_active  <= is_alloc && found && pick_play;
        end
        default: begin
          done_res      <= 1'b0;
          channel_index <= '0;
          stole_active  <= 1'b0;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/vca_ctrl.sv @@
module vca_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  vca_pkg::vca_sts_t sts,
  output vca_pkg::vca_cmd_t cmd
);
  import vca_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } state_t;

  state_t state;
  logic   slot_free;

  // result slot is free once the held item is taken
  assign slot_free = !out_valid || out_ready;

  assign in_ready  = (state == ST_IDLE);
  assign cmd.load  = (state == ST_IDLE) && in_valid;
  assign cmd.step  = (state == ST_SCAN);
  assign cmd.apply = (state == ST_APPLY) && slot_free;

  // sequencer and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // a new result fills the slot, otherwise a taken one empties it
      if (cmd.apply) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= sts.scan_op ? ST_SCAN : ST_APPLY;
          end
        end
        ST_SCAN: begin
          if (sts.hit || sts.last) begin
            state <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sim/vca_checker.sv @@
module voice_result_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [vca_pkg::ACT_W-1:0]         action,
  input  logic [vca_pkg::ENT_W-1:0]         entity,
  input  logic signed [vca_pkg::SUB_W-1:0]  entity_channel,
  input  logic [vca_pkg::NOW_W-1:0]         now,
  input  logic [vca_pkg::LEN_W-1:0]         sound_length,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic                              done_res,
  input  logic [vca_pkg::CIDX_W-1:0]        channel_index,
  input  logic                              stole_active,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [vca_pkg::ENT_W-1:0]         cfg_data,
  output int                                mismatches,
  output int                                waiting
);
  timeunit 1ns;
  timeprecision 1ps;
  import vca_pkg::*;

  typedef struct packed {
    logic              done;
    logic [CIDX_W-1:0] idx;
    logic              stole;
  } voice_result_t;

  // shadow copy of the channel table and the listener register
  logic [ENT_W-1:0]  owner_ent [CHANNELS];
  logic [SUB_W-1:0]  owner_sub [CHANNELS];
  logic [TIME_W-1:0] end_time  [CHANNELS];
  logic              playing   [CHANNELS];
  logic [ENT_W-1:0]  listener;

  voice_result_t expected_results[$];

  initial begin
    mismatches = 0;
    waiting = 0;
  end

  function automatic void wipe_channels();
    for (int i = 0; i < CHANNELS; i++) begin
      owner_ent[i] = '0;
      owner_sub[i] = '0;
      end_time[i]  = '0;
      playing[i]   = 1'b0;
    end
  endfunction

  // applies one request to the shadow table and returns the result it gives
  function automatic voice_result_t serve_request(logic [ACT_W-1:0] act, logic [ENT_W-1:0] ent,
                                                  logic [SUB_W-1:0] sub, logic [NOW_W-1:0] at,
                                                  logic [LEN_W-1:0] len);
    voice_result_t     r;
    int                pick;
    logic              hit;
    logic signed [31:0] best;
    logic signed [31:0] left;
    r = '0;
    pick = -1;
    hit = 1'b0;
    best = BEST_INIT;
    case (act)
      ACT_ALLOC: begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (!hit) begin
            // same owner on the same sub-channel, or on any with SUB_ANY, takes over at once
            if (sub != SUB_NONE && owner_ent[i] == ent &&
                (owner_sub[i] == sub || sub == SUB_ANY)) begin
              pick = i;
              hit = 1'b1;
            end else if (!(owner_ent[i] == listener && ent != listener && playing[i])) begin
              // least remaining time wins, wrapping signed compare
              left = end_time[i] - {1'b0, at};
              if (left < best) begin
                best = left;
                pick = i;
              end
            end
          end
        end
        if (pick >= 0) begin
          r.done = 1'b1;
          r.idx = pick[CIDX_W-1:0];
          r.stole = playing[pick];
          owner_ent[pick] = ent;
          owner_sub[pick] = sub;
          end_time[pick] = {1'b0, at} + {8'd0, len};
          playing[pick] = 1'b1;
        end
      end
      ACT_STOP: begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (!hit && owner_ent[i] == ent && owner_sub[i] == sub) begin
            hit = 1'b1;
            end_time[i] = '0;
            playing[i] = 1'b0;
            r.done = 1'b1;
            r.idx = i[CIDX_W-1:0];
          end
        end
      end
      ACT_CLEAR: wipe_channels();
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
  endtask

  task automatic check_field(string name, logic [CIDX_W-1:0] got, logic [CIDX_W-1:0] want);
    if (got !== want) report_mismatch(name, int'(got), int'(want));
  endtask

  // watch the three channels at every rising edge
  always @(posedge clk) begin
    voice_result_t want;
    if (rst) begin
      listener = '0;
      wipe_channels();
      expected_results.delete();
    end else begin
      if (out_valid === 1'b1 && out_ready === 1'b1) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result item", int'(channel_index), 0);
        end else begin
          want = expected_results.pop_front();
          check_field("done_res", CIDX_W'(done_res), CIDX_W'(want.done));
          check_field("channel_index", channel_index, want.idx);
          check_field("stole_active", CIDX_W'(stole_active), CIDX_W'(want.stole));
        end
      end
      if (in_valid === 1'b1 && in_ready === 1'b1)
        expected_results.push_back(serve_request(action, entity, entity_channel, now,
                                                 sound_length));
      if (cfg_valid === 1'b1 && cfg_ready === 1'b1)
        listener = cfg_data;
    end
    waiting = expected_results.size();
  end

endmodule

@@ sim/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import vca_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int RUN_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 12;
  localparam int PHASE_ITEMS = 380;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic [ENT_W-1:0] ent;
    logic [SUB_W-1:0] sub;
    logic [NOW_W-1:0] at;
    logic [LEN_W-1:0] len;
  } voice_req_t;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_ready;
  logic [ACT_W-1:0]        action;
  logic [ENT_W-1:0]        entity;
  logic signed [SUB_W-1:0] entity_channel;
  logic [NOW_W-1:0]        now;
  logic [LEN_W-1:0]        sound_length;
  logic                    out_valid;
  logic                    out_ready;
  logic                    done_res;
  logic [CIDX_W-1:0]       channel_index;
  logic                    stole_active;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [ENT_W-1:0]        cfg_data;
  int                      mismatches;
  int                      waiting;
  int                      cycles;
  bit                      quiet;

  // stimulus bookkeeping
  logic [ENT_W-1:0] listener_setting;
  logic [NOW_W-1:0] clock_now;
  logic [ENT_W+SUB_W-1:0] recent_owners[$];

  voice_channel_allocator u_dut (
    .clk, .rst, .in_valid, .in_ready, .action, .entity, .entity_channel, .now,
    .sound_length, .out_valid, .out_ready, .done_res, .channel_index, .stole_active,
    .cfg_valid, .cfg_ready, .cfg_data
  );

  voice_result_checker u_check (
    .clk, .rst, .in_valid, .in_ready, .action, .entity, .entity_channel, .now,
    .sound_length, .out_valid, .out_ready, .done_res, .channel_index, .stole_active,
    .cfg_valid, .cfg_ready, .cfg_data, .mismatches, .waiting
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run length guard
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side stalls at random outside the quiet stretch
  always @(negedge clk) begin
    out_ready = quiet || ($urandom_range(0, 99) >= 38);
  end

  function automatic voice_req_t make_req(logic [ACT_W-1:0] a, logic [ENT_W-1:0] e,
                                          logic [SUB_W-1:0] s, logic [NOW_W-1:0] t,
                                          logic [LEN_W-1:0] l);
    voice_req_t r;
    r.act = a;
    r.ent = e;
    r.sub = s;
    r.at = t;
    r.len = l;
    return r;
  endfunction

  // entered and left at a falling edge; valid stays up if the next item follows
  task automatic push_request(input voice_req_t r);
    while (!quiet && $urandom_range(0, 99) < 38) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    action = r.act;
    entity = r.ent;
    entity_channel = r.sub;
    now = r.at;
    sound_length = r.len;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // listener register is only written with nothing in flight
  task automatic write_listener(input logic [ENT_W-1:0] v);
    in_valid = 1'b0;
    while (waiting != 0) @(negedge clk);
    listener_setting = v;
    cfg_valid = 1'b1;
    cfg_data = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // mostly a handful of owners so that matches and steals happen often
  function automatic logic [ENT_W-1:0] pick_entity();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 20) return listener_setting;
    if (roll < 70) return ENT_W'($urandom_range(1, 5));
    if (roll < 76) return '0;
    if (roll < 82) return '1;
    return ENT_W'($urandom());
  endfunction

  task automatic run_random_phase(input int count);
    voice_req_t r;
    int roll;
    logic [ENT_W+SUB_W-1:0] pair;
    for (int k = 0; k < count; k++) begin
      // time mostly moves forward, with the odd jump anywhere
      if ($urandom_range(0, 99) < 3) clock_now = NOW_W'($urandom());
      else clock_now = clock_now + NOW_W'($urandom_range(0, 3000));
      r.at = clock_now;
      roll = $urandom_range(0, 99);
      if (roll < 10) r.len = '0;
      else if (roll < 20) r.len = LEN_W'($urandom());
      else r.len = LEN_W'($urandom_range(1, 8000));
      r.ent = pick_entity();
      r.sub = SUB_W'($urandom_range(0, 8) - 1);
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        r.act = ACT_CLEAR;
      end else if (roll < 6) begin
        r.act = ACT_UNUSED;
      end else if (roll < 36) begin
        r.act = ACT_STOP;
        // most stops aim at an owner that was recently given a channel
        if (recent_owners.size() != 0 && $urandom_range(0, 99) < 75) begin
          pair = recent_owners[$urandom_range(0, recent_owners.size() - 1)];
          r.ent = pair[ENT_W+SUB_W-1:SUB_W];
          r.sub = pair[SUB_W-1:0];
        end
      end else begin
        r.act = ACT_ALLOC;
        recent_owners.push_back({r.ent, r.sub});
        if (recent_owners.size() > 12) void'(recent_owners.pop_front());
      end
      push_request(r);
    end
  endtask

  initial begin
    logic [ENT_W-1:0] settings [5];
    rst = 1'b1;
    in_valid = 1'b0;
    action = ACT_ALLOC;
    entity = '0;
    entity_channel = '0;
    now = '0;
    sound_length = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    quiet = 1'b0;
    listener_setting = '0;
    clock_now = '0;
    settings[0] = 16'd0;
    settings[1] = 16'hffff;
    settings[2] = 16'd3;
    settings[3] = 16'd1;
    settings[4] = ENT_W'($urandom());
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part, listener is entity 3
    write_listener(16'd3);
    push_request(make_req(ACT_ALLOC, 16'd1, 4'd1, 31'd0, 24'd100));
    // same owner and sub-channel takes the entry back
    push_request(make_req(ACT_ALLOC, 16'd1, 4'd1, 31'd10, 24'd50));
    // sub-channel zero never takes over
    push_request(make_req(ACT_ALLOC, 16'd1, SUB_NONE, 31'd20, 24'hffffff));
    // any sub-channel of the same owner
    push_request(make_req(ACT_ALLOC, 16'd1, SUB_ANY, 31'd30, 24'd5));
    // end time lands exactly on the search start value
    push_request(make_req(ACT_ALLOC, 16'hffff, 4'd7, 31'h7fffffff, 24'd0));
    push_request(make_req(ACT_ALLOC, 16'd0, SUB_NONE, 31'd0, 24'd0));
    // end time wraps past the signed range
    push_request(make_req(ACT_ALLOC, 16'd2, 4'd2, 31'h7fffffff, 24'hffffff));
    push_request(make_req(ACT_STOP, 16'd1, SUB_ANY, 31'd0, 24'd0));
    push_request(make_req(ACT_STOP, 16'd9, 4'd5, 31'd0, 24'd0));
    // empty entries match a stop of entity zero
    push_request(make_req(ACT_STOP, 16'd0, SUB_NONE, 31'd0, 24'd0));
    push_request(make_req(ACT_UNUSED, 16'hffff, SUB_ANY, 31'h7fffffff, 24'hffffff));
    push_request(make_req(ACT_CLEAR, 16'd0, SUB_NONE, 31'd0, 24'd0));
    // listener fills the whole table, then an outsider finds nothing
    for (int i = 0; i < CHANNELS; i++)
      push_request(make_req(ACT_ALLOC, 16'd3, SUB_NONE, 31'd1000, 24'd1000));
    push_request(make_req(ACT_ALLOC, 16'd4, 4'd1, 31'd1500, 24'd10));
    push_request(make_req(ACT_ALLOC, 16'd3, 4'd5, 31'd1500, 24'd10));
    push_request(make_req(ACT_STOP, 16'd3, SUB_NONE, 31'd0, 24'd0));
    push_request(make_req(ACT_ALLOC, 16'd4, 4'd1, 31'd1600, 24'd10));
    push_request(make_req(ACT_CLEAR, 16'd0, SUB_NONE, 31'd0, 24'd0));

    // random phases, one listener setting each, the third without stalls
    for (int p = 0; p < 5; p++) begin
      write_listener(settings[p]);
      quiet = (p == 2);
      run_random_phase(PHASE_ITEMS);
    end
    quiet = 1'b0;
    in_valid = 1'b0;

    while (waiting != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
